### rtl/core/bgcd_pkg.sv
package bgcd_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHARED,
        S_STRIP_A,
        S_REDUCE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic merge;
        logic shift_both;
        logic shift_a;
        logic shift_b;
        logic sub_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic any_zero;
        logic both_even;
        logic a_even;
        logic b_even;
        logic a_eq_b;
    } t_status;

endpackage

### rtl/core/bgcd_datapath.sv
module bgcd_datapath
    import bgcd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_first_operand,
    input  logic [DATA_W-1:0] i_second_operand,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [DATA_W-1:0] o_divisor
);

    localparam int SHW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0]  r_a, n_a;
    logic [WIDTH-1:0]  r_b, n_b;
    logic [SHW-1:0]    r_shared, n_shared;
    logic [DATA_W-1:0] r_result, n_result;

    logic [WIDTH-1:0]  in_a;
    logic [WIDTH-1:0]  in_b;
    logic [WIDTH-1:0]  shifted;
    logic [DATA_W-1:0] shifted_out;
    logic [WIDTH:0]    diff_ab;
    logic [WIDTH-1:0]  diff_ba;

    generate
        if (WIDTH >= DATA_W) begin : g_wide
            assign in_a        = WIDTH'(i_first_operand);
            assign in_b        = WIDTH'(i_second_operand);
            assign shifted_out = shifted[DATA_W-1:0];
        end else begin : g_narrow
            assign in_a        = i_first_operand[WIDTH-1:0];
            assign in_b        = i_second_operand[WIDTH-1:0];
            assign shifted_out = {{(DATA_W-WIDTH){1'b0}}, shifted};
        end
    endgenerate

    assign shifted = r_a << r_shared;
    assign diff_ab = {1'b0, r_a} - {1'b0, r_b};
    assign diff_ba = r_b - r_a;

    assign o_status.any_zero  = (r_a == '0) || (r_b == '0);
    assign o_status.both_even = ~r_a[0] & ~r_b[0];
    assign o_status.a_even    = ~r_a[0];
    assign o_status.b_even    = ~r_b[0];
    assign o_status.a_eq_b    = (r_a == r_b);

    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_shared = r_shared;
        n_result = r_result;
        if (i_cmd.load) begin
            n_a      = in_a;
            n_b      = in_b;
            n_shared = '0;
        end
        if (i_cmd.merge) begin
            n_a = r_a | r_b;
        end
        if (i_cmd.shift_both) begin
            n_a      = r_a >> 1;
            n_b      = r_b >> 1;
            n_shared = r_shared + 1'b1;
        end
        if (i_cmd.shift_a) begin
            n_a = r_a >> 1;
        end
        if (i_cmd.shift_b) begin
            n_b = r_b >> 1;
        end
        if (i_cmd.sub_step) begin
            // both odd: keep the smaller, halve the difference
            if (diff_ab[WIDTH]) begin
                n_b = diff_ba >> 1;
            end else begin
                n_a = r_b;
                n_b = diff_ab[WIDTH-1:0] >> 1;
            end
        end
        if (i_cmd.load_out) begin
            n_result = shifted_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_shared <= n_shared;
        r_result <= n_result;
    end

    assign o_divisor = r_result;

endmodule

### rtl/core/bgcd_ctrl.sv
module bgcd_ctrl
    import bgcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.any_zero) begin
                    o_cmd.merge = 1'b1;
                    n_state     = S_FINISH;
                end else begin
                    n_state = S_SHARED;
                end
            end
            S_SHARED: begin
                if (i_status.both_even) begin
                    o_cmd.shift_both = 1'b1;
                end else begin
                    n_state = S_STRIP_A;
                end
            end
            S_STRIP_A: begin
                if (i_status.a_even) begin
                    o_cmd.shift_a = 1'b1;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.b_even) begin
                    o_cmd.shift_b = 1'b1;
                end else begin
                    o_cmd.sub_step = 1'b1;
                    if (i_status.a_eq_b) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/binary_gcd.sv
// binary_gcd: greatest common divisor of two unsigned operands (Stein's method)
//
// input beat on s_axis: tdata[31:0] first operand, tdata[63:32] second operand
// output beat on m_axis: tdata[31:0] divisor
// operands are taken modulo 2**WIDTH, the divisor is truncated to 32 bits
//
// one pair is worked at a time, at most one shift or subtract step per cycle on
// the operand register pair; when an operand is zero the pair goes from the
// check straight to the finish step, otherwise the shared twos, the remaining
// twos of the first operand and the reduce steps are worked in that order
// s_axis_tready is high only while no pair is in work, so the next pair is
// taken at the earliest in the idle state after the divisor is loaded
//
// the result sits in an output register, so a new pair is accepted while
// the previous divisor waits; a finished pair stalls in its last step until
// the output register is free
// reset (synchronous, active low) drops any pair in work and the pending beat
module binary_gcd
    import bgcd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // first_operand, second_operand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // divisor
);

    t_cmd    cmd;
    t_status status;

    bgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bgcd_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_first_operand  (s_axis_tdata[DATA_W-1:0]),
        .i_second_operand (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_divisor        (m_axis_tdata)
    );

endmodule
